// ===== hw/rtl/fpe_pkg.sv =====
// Shared constants and types for the frustum plane extract block.
// No dependencies.
package fpe_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Plane codes, in output order
  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP    = 3'd3;
  localparam logic [2:0] PLANE_NEAR   = 3'd4;
  localparam logic [2:0] PLANE_FAR    = 3'd5;

  localparam logic [1:0] ROW_W = 2'd3;

  // Status from the normalize unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } fpe_stat_t;

endpackage

// ===== hw/rtl/fpe_in_if.sv =====
// Input channel: one matrix row per item, valid/ready handshake.
// No dependencies.
interface fpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] elem_x;
  logic signed [31:0] elem_y;
  logic signed [31:0] elem_z;
  logic signed [31:0] elem_w;
  logic               finish;

  modport source (output valid, row_index, elem_x, elem_y, elem_z, elem_w, finish,
                  input ready);
  modport sink   (input valid, row_index, elem_x, elem_y, elem_z, elem_w, finish,
                  output ready);
endinterface

// ===== hw/rtl/fpe_out_if.sv =====
// Result channel: one plane per item, valid/ready handshake.
// No dependencies.
interface fpe_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         plane_index;
  logic signed [31:0] plane_a;
  logic signed [31:0] plane_b;
  logic signed [31:0] plane_c;
  logic signed [31:0] plane_d;
  logic               last_plane;

  modport source (output valid, plane_index, plane_a, plane_b, plane_c, plane_d, last_plane,
                  input ready);
  modport sink   (input valid, plane_index, plane_a, plane_b, plane_c, plane_d, last_plane,
                  output ready);
endinterface

// ===== hw/rtl/frustum_plane_extract_unit.sv =====
// Frustum plane extract top level: matrix row store, plane sequencer,
// output register. Depends on fpe_pkg, fpe_in_if, fpe_out_if, fpe_norm_unit.
//
// Usage: send the four matrix rows on in_ch, one item each; the item with
// finish set writes its row and then yields six plane items on out_ch in
// order left, right, bottom, top, near, far (last_plane on far). Rows not
// written since reset read as zero. cfg_we/cfg_wdata set the minimum normal
// length; write it only while the block is idle.
// A row without finish is only written to the matrix store. With finish,
// each plane goes through start, sum of squares and the bit-serial square
// root, then passes through saturated when its normal is not longer than
// the minimum, or else the shared divider normalizes it.
// in_ch.ready is low from a finish item until the far plane is taken.
// Throughput: one plane at a time; a stalled receiver holds the plane in
// the output register and the next plane waits until it is taken.
// Reset (synchronous, active low) clears the matrix store, the register
// and all control state.
module frustum_plane_extract_unit #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  fpe_in_if.sink       in_ch,
  fpe_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata
);
  import fpe_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [1:0]             state_r;
  logic [3:0][3:0][31:0]  mat_r;    // [row][col]
  logic [30:0]            min_len_r;
  logic [2:0]             plane_r;
  logic                   start_r;
  logic [3:0][31:0]       out_r;
  logic [2:0]             oidx_r;
  logic                   olast_r;

  logic                   in_acc;
  logic [1:0]             src_row;
  logic [3:0][32:0]       comp;
  fpe_stat_t              stat;
  logic [3:0][31:0]       res;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == T_IDLE);

  // Plane row combination
  assign src_row = plane_r[2:1];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (plane_r == PLANE_NEAR)
        comp[c] = {mat_r[src_row][c][31], mat_r[src_row][c]};
      else if (plane_r[0])
        comp[c] = {mat_r[ROW_W][c][31], mat_r[ROW_W][c]}
                - {mat_r[src_row][c][31], mat_r[src_row][c]};
      else
        comp[c] = {mat_r[ROW_W][c][31], mat_r[ROW_W][c]}
                + {mat_r[src_row][c][31], mat_r[src_row][c]};
    end
  end

  fpe_norm_unit #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .comp_in (comp),
    .min_len (min_len_r),
    .stat    (stat),
    .res     (res)
  );

  // Register and matrix store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
      mat_r     <= '0;
    end else begin
      if (cfg_we) min_len_r <= cfg_wdata;
      if (in_acc) begin
        mat_r[in_ch.row_index][0] <= in_ch.elem_x;
        mat_r[in_ch.row_index][1] <= in_ch.elem_y;
        mat_r[in_ch.row_index][2] <= in_ch.elem_z;
        mat_r[in_ch.row_index][3] <= in_ch.elem_w;
      end
    end
  end

  // Plane sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      plane_r <= PLANE_LEFT;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (in_acc && in_ch.finish) begin
            plane_r <= PLANE_LEFT;
            start_r <= 1'b1;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (stat.done) begin
            out_r   <= res;
            oidx_r  <= plane_r;
            olast_r <= (plane_r == PLANE_FAR);
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_ch.ready) begin
            if (plane_r == PLANE_FAR) begin
              state_r <= T_IDLE;
            end else begin
              plane_r <= plane_r + 3'd1;
              start_r <= 1'b1;
              state_r <= T_RUN;
            end
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = (state_r == T_OUT);
  assign out_ch.plane_index = oidx_r;
  assign out_ch.plane_a     = out_r[0];
  assign out_ch.plane_b     = out_r[1];
  assign out_ch.plane_c     = out_r[2];
  assign out_ch.plane_d     = out_r[3];
  assign out_ch.last_plane  = olast_r;

`ifndef NO_ASSERTIONS
  // No input taken while the normalize unit works
  assert property (@(posedge clk) disable iff (!rst_n) in_ch.ready |-> !stat.busy)
    else $error("input ready while normalize unit busy");

  // Unit finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n) stat.done |-> state_r == T_RUN)
    else $error("normalize done outside run state");

  // last_plane marks the far plane only
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_plane == (out_ch.plane_index == PLANE_FAR)))
    else $error("last_plane mismatch");

  // A finish item starts the unit on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.finish |=> start_r && plane_r == PLANE_LEFT)
    else $error("finish did not start plane run");
`endif

endmodule

// ===== hw/rtl/fpe_norm_unit.sv =====
// Plane normalize unit: sum of squares, bit-serial square root and a
// shared bit-serial divider. Depends on fpe_pkg.
module fpe_norm_unit #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [3:0][32:0]       comp_in,
  input  logic [30:0]            min_len,
  output fpe_pkg::fpe_stat_t     stat,
  output logic [3:0][31:0]       res
);
  import fpe_pkg::*;

  localparam int DW  = 33 + FRAC_BITS;
  localparam int CW  = $clog2(DW + 1);
  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_SQ   = 3'd1;
  localparam logic [2:0] C_SQRT = 3'd2;
  localparam logic [2:0] C_LOAD = 3'd3;
  localparam logic [2:0] C_DIV  = 3'd4;
  localparam logic [2:0] C_DONE = 3'd5;
  localparam logic [CW-1:0] SQRT_LAST = CW'(32);
  localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);

  logic [2:0]        state_r;
  logic [3:0][32:0]  comp_r;
  logic [1:0]        idx_r;
  logic [CW-1:0]     cnt_r;
  logic [65:0]       prod_r;
  logic [65:0]       acc_r;
  logic [35:0]       rem_r;
  logic [32:0]       root_r;
  logic [DW-1:0]     dvd_r;
  logic [33:0]       drem_r;
  logic [3:0][31:0]  res_r;

  logic [32:0]       sel;
  logic [32:0]       mag_w;
  logic [35:0]       srem_n;
  logic [35:0]       trial;
  logic [33:0]       drem_n;
  logic              qbit;
  logic [DW-1:0]     q_nxt;
  logic [31:0]       qsat;

  // Magnitude of the current component
  assign sel   = comp_r[idx_r];
  assign mag_w = sel[32] ? (~sel + 33'd1) : sel;

  // One square root digit
  assign srem_n = {rem_r[33:0], acc_r[65:64]};
  assign trial  = {1'b0, root_r, 2'b01};

  // One divide step
  assign drem_n = {drem_r[32:0], dvd_r[DW-1]};
  assign qbit   = (drem_n >= {1'b0, root_r});
  assign q_nxt  = {dvd_r[DW-2:0], qbit};

  // Signed, saturated quotient
  always_comb begin
    if (sel[32]) begin
      if (q_nxt > DW'(33'h0_8000_0000)) qsat = 32'h8000_0000;
      else qsat = ~q_nxt[31:0] + 32'd1;
    end else begin
      if (q_nxt > DW'(32'h7FFF_FFFF)) qsat = 32'h7FFF_FFFF;
      else qsat = q_nxt[31:0];
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            comp_r  <= comp_in;
            idx_r   <= '0;
            acc_r   <= '0;
            state_r <= C_SQ;
          end
        end
        C_SQ: begin
          if (idx_r != 2'd3) prod_r <= mag_w * mag_w;
          if (idx_r != 2'd0) acc_r <= acc_r + prod_r;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= C_SQRT;
          end
        end
        C_SQRT: begin
          acc_r <= {acc_r[63:0], 2'b00};
          if (srem_n >= trial) begin
            rem_r  <= srem_n - trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= srem_n;
            root_r <= {root_r[31:0], 1'b0};
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == SQRT_LAST) begin
            idx_r   <= '0;
            state_r <= C_LOAD;
          end
        end
        C_LOAD: begin
          if (root_r > {2'b00, min_len}) begin
            dvd_r   <= {mag_w, FRAC_BITS'(0)};
            drem_r  <= '0;
            cnt_r   <= '0;
            state_r <= C_DIV;
          end else begin
            // Short normal: pass through, saturated
            for (int i = 0; i < 4; i++) begin
              if (comp_r[i][32] != comp_r[i][31])
                res_r[i] <= comp_r[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
              else
                res_r[i] <= comp_r[i][31:0];
            end
            state_r <= C_DONE;
          end
        end
        C_DIV: begin
          drem_r <= qbit ? (drem_n - {1'b0, root_r}) : drem_n;
          dvd_r  <= q_nxt;
          cnt_r  <= cnt_r + CW'(1);
          if (cnt_r == DIV_LAST) begin
            res_r[idx_r] <= qsat;
            idx_r        <= idx_r + 2'd1;
            state_r      <= (idx_r == 2'd3) ? C_DONE : C_LOAD;
          end
        end
        C_DONE: begin
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = (state_r == C_DONE);
  assign res       = res_r;

endmodule
